[hw/rtl/fsba_pkg.sv]
// Shared types, codes and defaults for the fit strategy block allocator.
package fsba_pkg;

  localparam int NUM_PARTITIONS_DEF = 16;
  localparam int SIZE_BITS_DEF      = 16;

  localparam int FUNC_BITS     = 2;
  localparam int SLOT_BITS     = 4;
  localparam int AMOUNT_BITS   = 16;
  localparam int STRATEGY_BITS = 2;
  localparam int COUNT_BITS    = 5;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 5;

  localparam logic [FUNC_BITS-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_BITS-1:0] FUNC_RESTORE = 2'd1;
  localparam logic [FUNC_BITS-1:0] FUNC_PLACE   = 2'd2;

  localparam logic [STRATEGY_BITS-1:0] STRAT_FIRST = 2'd0;
  localparam logic [STRATEGY_BITS-1:0] STRAT_NEXT  = 2'd1;
  localparam logic [STRATEGY_BITS-1:0] STRAT_BEST  = 2'd2;
  localparam logic [STRATEGY_BITS-1:0] STRAT_WORST = 2'd3;

  localparam logic [CFG_IDX_BITS-1:0] CFG_STRATEGY    = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_COUNT = 1'd1;

  localparam logic [STRATEGY_BITS-1:0] STRATEGY_RESET    = STRAT_FIRST;
  localparam logic [COUNT_BITS-1:0]    BLOCK_COUNT_RESET = 5'd16;

  typedef struct packed {
    logic [FUNC_BITS-1:0]   func;
    logic [SLOT_BITS-1:0]   slot;
    logic [AMOUNT_BITS-1:0] amount;
  } req_t;

  typedef struct packed {
    logic                   granted;
    logic [SLOT_BITS-1:0]   chosen_slot;
    logic [AMOUNT_BITS-1:0] remaining_after;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic issue;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic issue_stop;
    logic drained;
  } status_t;

endpackage

[hw/rtl/fsba_ctrl.sv]
// Sequencer for the allocator: capture, scan or sweep, commit.
module fsba_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  fsba_pkg::status_t status,
  output fsba_pkg::cmd_t    cmd,
  output logic             busy
);
  import fsba_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    COMMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = SCAN;
        end
      end
      SCAN: begin
        cmd.issue = !status.issue_stop;
        if (status.drained) begin
          state_next = COMMIT;
        end
      end
      COMMIT: begin
        cmd.commit = 1'b1;
        state_next = IDLE;
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != IDLE);

endmodule

[hw/rtl/fsba_datapath.sv]
// Partition tables, scan counter, fit compare and result register.
module fsba_datapath #(
  parameter int NUM_PARTITIONS = fsba_pkg::NUM_PARTITIONS_DEF,
  parameter int SIZE_BITS      = fsba_pkg::SIZE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  fsba_pkg::req_t                   request,
  input  logic                             cfg_write,
  input  logic [fsba_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [fsba_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  fsba_pkg::cmd_t                   cmd,
  output fsba_pkg::status_t                status,
  output fsba_pkg::rsp_t                   result,
  output logic                             done
);
  import fsba_pkg::*;

  localparam int IW = $clog2(NUM_PARTITIONS);
  localparam int CW = $clog2(NUM_PARTITIONS + 1);

  logic [SIZE_BITS-1:0] orig_mem [NUM_PARTITIONS];
  logic [SIZE_BITS-1:0] rem_mem  [NUM_PARTITIONS];
  logic [NUM_PARTITIONS-1:0] orig_vld;
  logic [NUM_PARTITIONS-1:0] rem_vld;

  logic [STRATEGY_BITS-1:0] strategy;
  logic [COUNT_BITS-1:0]    block_count;
  logic [IW-1:0]            rover;

  logic [FUNC_BITS-1:0]     func_q;
  logic [SLOT_BITS-1:0]     slot_q;
  logic [SIZE_BITS-1:0]     amt_q;
  logic [STRATEGY_BITS-1:0] strat_q;
  logic [CW-1:0]            scan_n;
  logic [CW-1:0]            cnt;
  logic [IW-1:0]            pos;
  logic [IW-1:0]            pos_next;

  logic                     rd_pend;
  logic [IW-1:0]            rd_idx;
  logic [SIZE_BITS-1:0]     rd_data;
  logic                     rd_v;

  logic                     have_best;
  logic [IW-1:0]            best_idx;
  logic [SIZE_BITS-1:0]     best_cap;

  logic [CW-1:0]            used_n;
  logic [IW-1:0]            start_pos;
  logic [SIZE_BITS-1:0]     cap;
  logic                     fits;
  logic                     take;
  logic                     early;
  logic                     slot_ok;
  logic [SIZE_BITS-1:0]     diff;
  rsp_t                     result_next;

  always_comb begin
    if (32'(block_count) > 32'(NUM_PARTITIONS)) begin
      used_n = CW'(NUM_PARTITIONS);
    end else begin
      used_n = CW'(block_count);
    end
    if (request.func == FUNC_PLACE && strategy == STRAT_NEXT && CW'(rover) < used_n) begin
      start_pos = rover;
    end else begin
      start_pos = '0;
    end
  end

  always_comb begin
    if (CW'(pos) + CW'(1) == scan_n) begin
      pos_next = '0;
    end else begin
      pos_next = pos + IW'(1);
    end
  end

  always_comb begin
    cap  = rd_v ? rd_data : '0;
    fits = (amt_q <= cap);
    take = 1'b0;
    if (rd_pend && func_q == FUNC_PLACE && fits) begin
      if (!have_best) begin
        take = 1'b1;
      end else begin
        case (strat_q)
          STRAT_BEST:  take = (cap < best_cap);
          STRAT_WORST: take = (cap > best_cap);
          default:     take = 1'b0;
        endcase
      end
    end
  end

  assign early   = (strat_q == STRAT_FIRST || strat_q == STRAT_NEXT) && have_best;
  assign slot_ok = (32'(slot_q) < 32'(NUM_PARTITIONS));
  assign diff    = best_cap - amt_q;

  assign status.issue_stop = (cnt == scan_n) || early;
  assign status.drained    = status.issue_stop && !rd_pend;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      strategy    <= STRATEGY_RESET;
      block_count <= BLOCK_COUNT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_STRATEGY:    strategy    <= cfg_data[STRATEGY_BITS-1:0];
        CFG_BLOCK_COUNT: block_count <= cfg_data[COUNT_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Capture the item and run the scan counter.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_q  <= request.func;
      slot_q  <= request.slot;
      amt_q   <= SIZE_BITS'(request.amount);
      strat_q <= strategy;
      pos     <= start_pos;
      case (request.func)
        FUNC_PLACE:   scan_n <= used_n;
        FUNC_RESTORE: scan_n <= CW'(NUM_PARTITIONS);
        default:      scan_n <= '0;
      endcase
    end else if (cmd.issue) begin
      pos <= pos_next;
    end
    if (cmd.issue) begin
      rd_idx <= pos;
      if (func_q == FUNC_RESTORE) begin
        rd_data <= orig_mem[pos];
        rd_v    <= orig_vld[pos];
      end else begin
        rd_data <= rem_mem[pos];
        rd_v    <= rem_vld[pos];
      end
    end
    if (take) begin
      best_idx <= rd_idx;
      best_cap <= cap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rd_pend   <= 1'b0;
      have_best <= 1'b0;
    end else begin
      rd_pend <= cmd.issue;
      if (cmd.capture) begin
        cnt       <= '0;
        have_best <= 1'b0;
      end else begin
        if (cmd.issue) begin
          cnt <= cnt + CW'(1);
        end
        if (take) begin
          have_best <= 1'b1;
        end
      end
    end
  end

  // Table storage.
  always_ff @(posedge clk) begin
    if (rd_pend && func_q == FUNC_RESTORE) begin
      rem_mem[rd_idx] <= rd_data;
    end else if (cmd.commit && func_q == FUNC_LOAD && slot_ok) begin
      rem_mem[IW'(slot_q)] <= amt_q;
    end else if (cmd.commit && func_q == FUNC_PLACE && have_best) begin
      rem_mem[best_idx] <= diff;
    end
    if (cmd.commit && func_q == FUNC_LOAD && slot_ok) begin
      orig_mem[IW'(slot_q)] <= amt_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      orig_vld <= '0;
      rem_vld  <= '0;
    end else begin
      if (rd_pend && func_q == FUNC_RESTORE) begin
        rem_vld[rd_idx] <= rd_v;
      end else if (cmd.commit && func_q == FUNC_LOAD && slot_ok) begin
        rem_vld[IW'(slot_q)] <= 1'b1;
      end else if (cmd.commit && func_q == FUNC_PLACE && have_best) begin
        rem_vld[best_idx] <= 1'b1;
      end
      if (cmd.commit && func_q == FUNC_LOAD && slot_ok) begin
        orig_vld[IW'(slot_q)] <= 1'b1;
      end
    end
  end

  // Result and next-fit pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      rover <= '0;
      done  <= 1'b0;
    end else begin
      done <= cmd.commit;
      if (cmd.commit) begin
        if (func_q == FUNC_RESTORE) begin
          rover <= '0;
        end else if (func_q == FUNC_PLACE && have_best && strat_q == STRAT_NEXT) begin
          rover <= best_idx;
        end
      end
    end
  end

  always_comb begin
    result_next = '0;
    case (func_q)
      FUNC_LOAD: begin
        result_next.granted = slot_ok;
      end
      FUNC_RESTORE: begin
        result_next.granted = 1'b1;
      end
      FUNC_PLACE: begin
        if (have_best) begin
          result_next.granted         = 1'b1;
          result_next.chosen_slot     = SLOT_BITS'(best_idx);
          result_next.remaining_after = AMOUNT_BITS'(diff);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result <= result_next;
    end
  end

endmodule

[hw/rtl/fit_strategy_block_allocator.sv]
// Top level of the fit strategy block allocator.
//
// Channels: an item on request (func, slot, amount) transfers at a rising edge
// with start high and busy low. Each item gives one result on result, shown for
// exactly one cycle with done high; the receiver cannot stall it. Registers
// strategy (index 0) and block_count (index 1) are written through cfg_write,
// cfg_index and cfg_data; the user must write them only while the block is
// idle, which the block itself does not enforce.
// Scan: n is the number of table reads the scan performs, one read per cycle
// from the single read port of the partition tables. A load or an unused code
// has n = 0, a restore copies every partition (n = NUM_PARTITIONS), a placement
// reads up to min(block_count, NUM_PARTITIONS) entries; first and next fit stop
// at most one read past the first fitting entry. The next item is accepted in
// the cycle done is high.
// Reset: strategy returns to first fit, block_count to 16, all capacities read
// as zero and the next-fit pointer returns to zero.
module fit_strategy_block_allocator #(
  parameter int NUM_PARTITIONS = fsba_pkg::NUM_PARTITIONS_DEF,
  parameter int SIZE_BITS      = fsba_pkg::SIZE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  fsba_pkg::req_t                     request,
  output logic                               done,
  output fsba_pkg::rsp_t                     result,
  input  logic                               cfg_write,
  input  logic [fsba_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [fsba_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import fsba_pkg::*;

  cmd_t    cmd;
  status_t status;

  fsba_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  fsba_datapath #(
    .NUM_PARTITIONS (NUM_PARTITIONS),
    .SIZE_BITS      (SIZE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .result    (result),
    .done      (done)
  );

endmodule
